// File: rtl/bthal_pkg.sv
// Package for the boundary tag heap allocator: state, op and status codes,
// and the request size helper. No dependencies.
package bthal_pkg;

    // Width for sums of pointers and tag sizes
    localparam int SW = 33;
    // Width of a block size in words derived from a request
    localparam int NW = 13;
    localparam logic [14:0] MAX_BYTES = 15'd16384;
    localparam logic [31:0] SPLIT_SLACK = 32'd4;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_REALLOC = 3'd2,
        OP_READ    = 3'd3,
        OP_WRITE   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_INVALID = 2'd2,
        ST_SIZE    = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_RW_RD, S_RW_DAT, S_RW_WR,
        S_V_RD, S_V_H, S_V_FR, S_V_F, S_RG_RD, S_RG_W, S_G_REM, S_G_REL,
        S_A_INIT, S_A_LOOP, S_A_CHK, S_A_END, S_A_SPL, S_A_SPR,
        S_MV_CHK, S_CP_TEST, S_CP_WR,
        S_R_RD, S_R_H, S_R_N, S_R_NW, S_R_P, S_R_PW, S_R_FIN,
        S_TAG_H, S_TAG_F, S_DONE
    } state_t;

    // Round bytes up to 8, convert to words, add header and footer
    function automatic logic [NW-1:0] words_for(input logic [14:0] bytes);
        logic [15:0] r;
        r = {1'b0, bytes} + 16'd7;
        words_for = NW'({r[15:3], 1'b0}) + NW'(2);
    endfunction

endpackage

// File: rtl/boundary_tag_heap_allocator_unit.sv
// Top level of the boundary tag heap allocator: sequencer, heap memory
// and result register. Depends on bthal_pkg.
//
// Channel  Dir  Width  Contents
// s_*      in   64     op, size_bytes, address, write_data
// m_*      out  48     result_address, read_data, status
//
// One word at a time: s_tready is high only while the sequencer is idle.
// An op rejected at dispatch goes straight to its result, a read or a write
// makes one heap access, and other ops visit heap blocks in turn; best-fit
// walks read one block header per block visited, and the move copy reads and
// then writes each payload word, all through the single heap memory port.
// The result waits in m_tdata until m_tready; no new word is taken meanwhile.
// Reset clears control state; the heap memory is not cleared.
module boundary_tag_heap_allocator_unit #(
    parameter int HEAP_WORDS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] op, [17:3] size_bytes, [29:18] address, [61:30] write_data
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [11:0] result_address, [43:12] read_data, [45:44] status
    output logic [47:0] m_tdata
);
    import bthal_pkg::*;

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int PW = (AW + 1 > 13) ? AW + 1 : 13;

    function automatic logic [SW-1:0] zp(input logic [PW-1:0] x);
        zp = SW'(x);
    endfunction

    function automatic logic [SW-1:0] zs(input logic [31:0] x);
        zs = SW'(x);
    endfunction

    state_t         state_reg, state_next;
    state_t         alloc_ret_reg, alloc_ret_next;
    state_t         rel_ret_reg, rel_ret_next;
    state_t         tag_ret_reg, tag_ret_next;
    logic [2:0]     op_reg, op_next;
    logic [14:0]    size_reg, size_next;
    logic [11:0]    addr_reg, addr_next;
    logic [31:0]    wdata_reg, wdata_next;
    logic [PW-1:0]  top_reg, top_next;
    logic [PW-1:0]  hint_reg, hint_next;
    logic           hv_reg, hv_next;
    logic [PW-1:0]  res_reg, res_next;
    logic [31:0]    data_reg, data_next;
    logic [1:0]     st_reg, st_next;
    logic [PW-1:0]  p_reg, p_next;
    logic [31:0]    hdr_reg, hdr_next;
    logic [31:0]    s_reg, s_next;
    logic [NW-1:0]  need_reg, need_next;
    logic [PW-1:0]  n_reg, n_next;
    logic [31:0]    rem_reg, rem_next;
    logic [PW-1:0]  cur_reg, cur_next;
    logic [PW-1:0]  bp_reg, bp_next;
    logic [31:0]    bs_reg, bs_next;
    logic           found_reg, found_next;
    logic [PW-1:0]  rp_reg, rp_next;
    logic [31:0]    rs_reg, rs_next;
    logic [PW-1:0]  tp_reg, tp_next;
    logic [31:0]    ts_reg, ts_next;
    logic           tu_reg, tu_next;
    logic [PW-1:0]  i_reg, i_next;

    logic [31:0]    mem [HEAP_WORDS];
    logic [31:0]    mem_q_reg;
    logic           mem_ok_reg;
    logic [PW-1:0]  mem_addr;
    logic           mem_we;
    logic [31:0]    mem_wdata;
    logic           mem_in;
    logic [31:0]    rdata;

    // Heap memory: one port, registered read, out of range reads give zero
    assign mem_in = zp(mem_addr) < SW'(HEAP_WORDS);
    assign rdata  = mem_ok_reg ? mem_q_reg : 32'd0;

    always_ff @(posedge clk)
    begin
        if (mem_we && mem_in)
        begin
            mem[mem_addr[AW-1:0]] <= mem_wdata;
        end
        mem_q_reg  <= mem[mem_addr[AW-1:0]];
        mem_ok_reg <= mem_in;
    end

    // Advance control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            top_reg   <= PW'(1);
            hint_reg  <= '0;
            hv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            hint_reg  <= hint_next;
            hv_reg    <= hv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alloc_ret_reg <= alloc_ret_next;
        rel_ret_reg   <= rel_ret_next;
        tag_ret_reg   <= tag_ret_next;
        op_reg        <= op_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        wdata_reg     <= wdata_next;
        res_reg       <= res_next;
        data_reg      <= data_next;
        st_reg        <= st_next;
        p_reg         <= p_next;
        hdr_reg       <= hdr_next;
        s_reg         <= s_next;
        need_reg      <= need_next;
        n_reg         <= n_next;
        rem_reg       <= rem_next;
        cur_reg       <= cur_next;
        bp_reg        <= bp_next;
        bs_reg        <= bs_next;
        found_reg     <= found_next;
        rp_reg        <= rp_next;
        rs_reg        <= rs_next;
        tp_reg        <= tp_next;
        ts_reg        <= ts_next;
        tu_reg        <= tu_next;
        i_reg         <= i_next;
    end

    // Sequence the op and compute next register values
    always_comb
    begin
        logic [31:0] sz;
        logic        stop;
        sz             = rdata & 32'hFFFF_FFFE;
        stop           = 1'b0;
        state_next     = state_reg;
        alloc_ret_next = alloc_ret_reg;
        rel_ret_next   = rel_ret_reg;
        tag_ret_next   = tag_ret_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        wdata_next     = wdata_reg;
        top_next       = top_reg;
        hint_next      = hint_reg;
        hv_next        = hv_reg;
        res_next       = res_reg;
        data_next      = data_reg;
        st_next        = st_reg;
        p_next         = p_reg;
        hdr_next       = hdr_reg;
        s_next         = s_reg;
        need_next      = need_reg;
        n_next         = n_reg;
        rem_next       = rem_reg;
        cur_next       = cur_reg;
        bp_next        = bp_reg;
        bs_next        = bs_reg;
        found_next     = found_reg;
        rp_next        = rp_reg;
        rs_next        = rs_reg;
        tp_next        = tp_reg;
        ts_next        = ts_reg;
        tu_next        = tu_reg;
        i_next         = i_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tdata[2:0];
                    size_next  = s_tdata[17:3];
                    addr_next  = s_tdata[29:18];
                    wdata_next = s_tdata[61:30];
                    st_next    = ST_OK;
                    res_next   = '0;
                    data_next  = '0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_DONE;
                p_next     = PW'(addr_reg) - PW'(1);
                need_next  = words_for(size_reg);
                case (op_reg)
                    OP_ALLOC, OP_REALLOC:
                    begin
                        if (size_reg > MAX_BYTES)
                        begin
                            st_next = ST_SIZE;
                        end
                        else if (op_reg == OP_ALLOC || addr_reg == 12'd0)
                        begin
                            if (size_reg != 15'd0)
                            begin
                                alloc_ret_next = S_DONE;
                                state_next     = S_A_INIT;
                            end
                        end
                        else if (addr_reg < 12'd2)
                        begin
                            st_next = ST_INVALID;
                        end
                        else
                        begin
                            state_next = S_V_RD;
                        end
                    end
                    OP_FREE:
                    begin
                        if (addr_reg == 12'd1)
                        begin
                            st_next = ST_INVALID;
                        end
                        else if (addr_reg != 12'd0)
                        begin
                            state_next = S_V_RD;
                        end
                    end
                    OP_READ, OP_WRITE:
                    begin
                        if (addr_reg == 12'd0 || PW'(addr_reg) >= top_reg)
                        begin
                            st_next = ST_INVALID;
                        end
                        else if (op_reg == OP_READ)
                        begin
                            state_next = S_RW_RD;
                        end
                        else
                        begin
                            state_next = S_RW_WR;
                        end
                    end
                    default:
                    begin
                        st_next = ST_INVALID;
                    end
                endcase
            end
            S_RW_RD:
            begin
                state_next = S_RW_DAT;
            end
            S_RW_DAT:
            begin
                data_next  = rdata;
                state_next = S_DONE;
            end
            S_RW_WR:
            begin
                state_next = S_DONE;
            end
            // Check the block tags before free or realloc
            S_V_RD:
            begin
                state_next = S_V_H;
            end
            S_V_H:
            begin
                hdr_next = rdata;
                s_next   = sz;
                if (!rdata[0] || sz < 32'd2 || zp(p_reg) + zs(sz) > zp(top_reg))
                begin
                    st_next    = ST_INVALID;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_V_FR;
                end
            end
            S_V_FR:
            begin
                state_next = S_V_F;
            end
            S_V_F:
            begin
                n_next = p_reg + s_reg[PW-1:0];
                if (rdata != hdr_reg)
                begin
                    st_next    = ST_INVALID;
                    state_next = S_DONE;
                end
                else if (op_reg == OP_FREE || size_reg == 15'd0)
                begin
                    rp_next      = p_reg;
                    rel_ret_next = S_DONE;
                    state_next   = S_R_RD;
                end
                else if (zs(s_reg) >= SW'(need_reg))
                begin
                    res_next   = PW'(addr_reg);
                    state_next = S_DONE;
                end
                else if (zp(p_reg) + zs(s_reg) < zp(top_reg))
                begin
                    state_next = S_RG_RD;
                end
                else
                begin
                    alloc_ret_next = S_MV_CHK;
                    state_next     = S_A_INIT;
                end
            end
            // Grow in place into a free next block
            S_RG_RD:
            begin
                state_next = S_RG_W;
            end
            S_RG_W:
            begin
                if (!rdata[0] && sz >= 32'd2 && zp(n_reg) + zs(sz) <= zp(top_reg)
                    && zs(s_reg) + zs(sz) >= SW'(need_reg))
                begin
                    if (hv_reg && hint_reg > p_reg && zp(hint_reg) < zp(n_reg) + zs(sz))
                    begin
                        hint_next = p_reg;
                    end
                    rem_next     = s_reg + sz - 32'(need_reg);
                    tp_next      = p_reg;
                    ts_next      = 32'(need_reg);
                    tu_next      = 1'b1;
                    tag_ret_next = S_G_REM;
                    res_next     = PW'(addr_reg);
                    state_next   = S_TAG_H;
                end
                else
                begin
                    alloc_ret_next = S_MV_CHK;
                    state_next     = S_A_INIT;
                end
            end
            S_G_REM:
            begin
                if (rem_reg > 32'd1)
                begin
                    tp_next      = p_reg + PW'(need_reg);
                    ts_next      = rem_reg;
                    tu_next      = 1'b0;
                    tag_ret_next = S_G_REL;
                    state_next   = S_TAG_H;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_G_REL:
            begin
                rp_next      = p_reg + PW'(need_reg);
                rel_ret_next = S_DONE;
                state_next   = S_R_RD;
            end
            // Best-fit walk over the implicit block list
            S_A_INIT:
            begin
                cur_next   = hv_reg ? hint_reg : PW'(1);
                found_next = 1'b0;
                state_next = S_A_LOOP;
            end
            S_A_LOOP:
            begin
                state_next = (cur_reg < top_reg) ? S_A_CHK : S_A_END;
            end
            S_A_CHK:
            begin
                if (sz < 32'd2 || zp(cur_reg) + zs(sz) > zp(top_reg))
                begin
                    state_next = S_A_END;
                end
                else
                begin
                    if (!rdata[0] && zs(sz) >= SW'(need_reg) && (!found_reg || sz < bs_reg))
                    begin
                        bp_next    = cur_reg;
                        bs_next    = sz;
                        found_next = 1'b1;
                        stop       = (zs(sz) == SW'(need_reg));
                    end
                    cur_next   = cur_reg + sz[PW-1:0];
                    state_next = stop ? S_A_END : S_A_LOOP;
                end
            end
            S_A_END:
            begin
                st_next = ST_OK;
                if (found_reg)
                begin
                    res_next   = bp_reg + PW'(1);
                    tp_next    = bp_reg;
                    tu_next    = 1'b1;
                    rem_next   = bs_reg - 32'(need_reg);
                    state_next = S_TAG_H;
                    if (bs_reg - 32'(need_reg) <= SPLIT_SLACK)
                    begin
                        ts_next      = bs_reg;
                        tag_ret_next = alloc_ret_reg;
                    end
                    else
                    begin
                        ts_next      = 32'(need_reg);
                        tag_ret_next = S_A_SPL;
                    end
                end
                else if (zp(top_reg) + SW'(need_reg) <= SW'(HEAP_WORDS))
                begin
                    res_next     = top_reg + PW'(1);
                    tp_next      = top_reg;
                    ts_next      = 32'(need_reg);
                    tu_next      = 1'b1;
                    top_next     = top_reg + PW'(need_reg);
                    tag_ret_next = alloc_ret_reg;
                    state_next   = S_TAG_H;
                end
                else
                begin
                    res_next   = '0;
                    st_next    = ST_OOM;
                    state_next = alloc_ret_reg;
                end
            end
            S_A_SPL:
            begin
                tp_next      = bp_reg + PW'(need_reg);
                ts_next      = rem_reg;
                tu_next      = 1'b0;
                tag_ret_next = S_A_SPR;
                state_next   = S_TAG_H;
            end
            S_A_SPR:
            begin
                rp_next      = bp_reg + PW'(need_reg);
                rel_ret_next = alloc_ret_reg;
                state_next   = S_R_RD;
            end
            // Copy the old payload into the moved block, then free the old one
            S_MV_CHK:
            begin
                i_next     = '0;
                state_next = (st_reg == ST_OK) ? S_CP_TEST : S_DONE;
            end
            S_CP_TEST:
            begin
                if (zp(i_reg) + SW'(2) < zs(s_reg))
                begin
                    state_next = S_CP_WR;
                end
                else
                begin
                    rp_next      = p_reg;
                    rel_ret_next = S_DONE;
                    state_next   = S_R_RD;
                end
            end
            S_CP_WR:
            begin
                i_next     = i_reg + PW'(1);
                state_next = S_CP_TEST;
            end
            // Release a block and merge with free neighbors
            S_R_RD:
            begin
                state_next = S_R_H;
            end
            S_R_H:
            begin
                rs_next      = sz;
                tp_next      = rp_reg;
                ts_next      = sz;
                tu_next      = 1'b0;
                tag_ret_next = S_R_N;
                state_next   = S_TAG_H;
            end
            S_R_N:
            begin
                n_next     = rp_reg + rs_reg[PW-1:0];
                state_next = (zp(rp_reg) + zs(rs_reg) < zp(top_reg)) ? S_R_NW : S_R_P;
            end
            S_R_NW:
            begin
                state_next = S_R_P;
                if (!rdata[0] && sz >= 32'd2 && zp(n_reg) + zs(sz) <= zp(top_reg))
                begin
                    rs_next      = rs_reg + sz;
                    tp_next      = rp_reg;
                    ts_next      = rs_reg + sz;
                    tu_next      = 1'b0;
                    tag_ret_next = S_R_P;
                    state_next   = S_TAG_H;
                end
            end
            S_R_P:
            begin
                state_next = (rp_reg > PW'(1)) ? S_R_PW : S_R_FIN;
            end
            S_R_PW:
            begin
                state_next = S_R_FIN;
                if (!rdata[0] && sz >= 32'd2 && zs(sz) <= zp(rp_reg) - SW'(1))
                begin
                    rp_next      = rp_reg - sz[PW-1:0];
                    rs_next      = rs_reg + sz;
                    tp_next      = rp_reg - sz[PW-1:0];
                    ts_next      = rs_reg + sz;
                    tu_next      = 1'b0;
                    tag_ret_next = S_R_FIN;
                    state_next   = S_TAG_H;
                end
            end
            S_R_FIN:
            begin
                if (!hv_reg || rp_reg < hint_reg)
                begin
                    hint_next = rp_reg;
                    hv_next   = 1'b1;
                end
                if (zp(rp_reg) + zs(rs_reg) == zp(top_reg))
                begin
                    top_next = rp_reg;
                end
                state_next = rel_ret_reg;
            end
            // Write header then footer
            S_TAG_H:
            begin
                state_next = S_TAG_F;
            end
            S_TAG_F:
            begin
                state_next = tag_ret_reg;
            end
            S_DONE:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Drive the memory port and the handshakes
    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        mem_addr  = '0;
        mem_we    = 1'b0;
        mem_wdata = {ts_reg[31:1], tu_reg};
        case (state_reg)
            S_IDLE:    s_tready = 1'b1;
            S_RW_RD:   mem_addr = PW'(addr_reg);
            S_RW_WR:
            begin
                mem_addr  = PW'(addr_reg);
                mem_we    = 1'b1;
                mem_wdata = wdata_reg;
            end
            S_V_RD:    mem_addr = p_reg;
            S_V_FR:    mem_addr = p_reg + s_reg[PW-1:0] - PW'(1);
            S_RG_RD:   mem_addr = n_reg;
            S_A_LOOP:  mem_addr = cur_reg;
            S_CP_TEST: mem_addr = p_reg + PW'(1) + i_reg;
            S_CP_WR:
            begin
                mem_addr  = res_reg + i_reg;
                mem_we    = 1'b1;
                mem_wdata = rdata;
            end
            S_R_RD:    mem_addr = rp_reg;
            S_R_N:     mem_addr = rp_reg + rs_reg[PW-1:0];
            S_R_P:     mem_addr = rp_reg - PW'(1);
            S_TAG_H:
            begin
                mem_addr = tp_reg;
                mem_we   = 1'b1;
            end
            S_TAG_F:
            begin
                mem_addr = tp_reg + ts_reg[PW-1:0] - PW'(1);
                mem_we   = 1'b1;
            end
            S_DONE:    m_tvalid = 1'b1;
            default:   mem_we = 1'b0;
        endcase
    end

    assign m_tdata = {2'b00, st_reg, data_reg, res_reg[11:0]};

`ifndef SYNTHESIS
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        zp(top_reg) <= SW'(HEAP_WORDS))
        else $error("heap top beyond heap size");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_alloc_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && op_reg == OP_ALLOC && st_reg == ST_OK && size_reg != 15'd0
        |-> res_reg != '0)
        else $error("successful alloc returned null");

    a_hint_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        hv_reg |-> hint_reg != '0)
        else $error("free hint points at reserved word");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_DISP)
        else $error("accepted word not dispatched");
`endif

endmodule
